// ===== rtl/core/mandelbrot_escape_time_unit_macros.svh =====
// Assertion helpers used by the escape-time unit RTL
`ifndef MANDELBROT_ESCAPE_TIME_UNIT_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_UNIT_MACROS_SVH

// same-cycle implication
`define MBE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mbe: same-cycle check failed");

// next-cycle implication
`define MBE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mbe: next-cycle check failed");

`endif

// ===== rtl/core/mbe_pkg.sv =====
package mbe_pkg;

	localparam int DIM_DEF   = 4096;
	localparam int FRAC_DEF  = 56;
	localparam int PIX_W     = 12;
	localparam int CNT_W     = 16;
	localparam int WORD_W    = 64;
	localparam int CFG_IDX_W = 3;

	localparam logic [WORD_W-1:0] SMIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [WORD_W-1:0] SMAX = {1'b0, {(WORD_W-1){1'b1}}};

	localparam logic [CNT_W-1:0] ITER_RST = 16'd256;

	localparam logic [CFG_IDX_W-1:0] REG_X_MIN  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MAX  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_STEP = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ITER   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_THR    = 3'd5;

	typedef struct packed {
		logic start;
		logic neg;
	} mbe_mul_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mbe_mul_rsp_t;

endpackage

// ===== rtl/core/mbe_cfg_if.sv =====
interface mbe_cfg_if import mbe_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WORD_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/mbe_pix_if.sv =====
interface mbe_pix_if import mbe_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;

	modport source (output valid, pixel_x, pixel_y, input ready);
	modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

// ===== rtl/core/mbe_res_if.sv =====
interface mbe_res_if import mbe_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_x;
	logic [PIX_W-1:0] out_y;
	logic [CNT_W-1:0] iterations;
	logic             escaped;
	logic [CNT_W-1:0] peak_count;

	modport source (output valid, out_x, out_y, iterations, escaped, peak_count, input ready);
	modport sink (input valid, out_x, out_y, iterations, escaped, peak_count, output ready);
endinterface

// ===== rtl/core/mbe_mul.sv =====
module mbe_mul import mbe_pkg::*; #(
	parameter int FRAC_BITS = FRAC_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mbe_mul_req_t          req,
	input  logic [WORD_W-1:0]     a,
	input  logic [WORD_W-1:0]     b,
	output mbe_mul_rsp_t          rsp,
	output logic [2*WORD_W-1:0]   prod,
	output logic [WORD_W-1:0]     fixed
);

	localparam int HALF = WORD_W / 2;

	logic [WORD_W-1:0]   a_q, b_q;
	logic                neg_q;
	logic [2:0]          step_q;
	logic                busy_q, done_q;
	logic [WORD_W-1:0]   pp_q;
	logic [1:0]          pp_sh_q;
	logic [2*WORD_W-1:0] acc_q;
	logic [WORD_W-1:0]   fix_q;

	logic [HALF-1:0]     a_sel, b_sel;
	logic [2*WORD_W-1:0] pp_ext, q_full;
	logic [WORD_W-1:0]   q, fix_d;
	logic                ovf;

	assign a_sel = step_q[1] ? a_q[WORD_W-1:HALF] : a_q[HALF-1:0];
	assign b_sel = step_q[0] ? b_q[WORD_W-1:HALF] : b_q[HALF-1:0];

	always_comb begin
		case (pp_sh_q)
			2'd0:    pp_ext = {{WORD_W{1'b0}}, pp_q};
			2'd1:    pp_ext = {{HALF{1'b0}}, pp_q, {HALF{1'b0}}};
			default: pp_ext = {pp_q, {WORD_W{1'b0}}};
		endcase
	end

	// truncate toward zero, apply sign, saturate
	always_comb begin
		q_full = acc_q >> FRAC_BITS;
		q      = q_full[WORD_W-1:0];
		ovf    = |q_full[2*WORD_W-1:WORD_W];
		if (ovf) begin
			fix_d = neg_q ? SMIN : SMAX;
		end else if (neg_q) begin
			fix_d = q[WORD_W-1] ? SMIN : (~q + 1'b1);
		end else begin
			fix_d = q[WORD_W-1] ? SMAX : q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !req.start && busy_q && (step_q == 3'd5);
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == 3'd5) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= a;
			b_q   <= b;
			neg_q <= req.neg;
			acc_q <= '0;
		end else if (busy_q) begin
			if (!step_q[2]) begin
				pp_q    <= {{HALF{1'b0}}, a_sel} * {{HALF{1'b0}}, b_sel};
				pp_sh_q <= {step_q[1] & step_q[0], step_q[1] ^ step_q[0]};
			end
			if (step_q != 3'd0 && step_q <= 3'd4) begin
				acc_q <= acc_q + pp_ext;
			end
			if (step_q == 3'd5) begin
				fix_q <= fix_d;
			end
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign prod     = acc_q;
	assign fixed    = fix_q;

endmodule

// ===== rtl/core/mandelbrot_escape_time_unit.sv =====
// Mandelbrot escape-time unit.
// Channels: cfg writes one register per beat (index 0..5, others ignored, always ready);
// pix carries one pixel coordinate per beat; res returns one beat per pixel with the
// coordinate, iteration count, escaped flag and the running peak of escaped counts.
// Registers are to be written only while the unit is idle; the unit does not enforce this.
// One pixel at a time: pix.ready is high only in the idle state. All products run
// through one shared 32x32 multiplier; a 64x64 product is built from four partial
// products, a final accumulate, truncation and saturation. Coordinate mapping costs two
// products, each z iteration three products plus bookkeeping. pix.ready returns as the
// result is loaded into the output register. A finished result sits in the output
// register; the next pixel is accepted meanwhile, and only the hand-over of its result
// waits while res.ready stays low.
// Reset restores the default view (x_min -2.0, y_max 1.5, step 2^-8, 256 iterations,
// threshold 4.0), clears the peak and drops any pending result.
`include "mandelbrot_escape_time_unit_macros.svh"

module mandelbrot_escape_time_unit import mbe_pkg::*; #(
	parameter int MAX_DIM   = DIM_DEF,
	parameter int FRAC_BITS = FRAC_DEF
) (
	input logic       clk,
	input logic       arst_n,
	mbe_cfg_if.sink   cfg,
	mbe_pix_if.sink   pix,
	mbe_res_if.source res
);

	localparam logic [PIX_W-1:0]    PIX_MASK  = PIX_W'((MAX_DIM - 1) & 'hFFF);
	localparam logic [WORD_W-1:0]   X_MIN_RST = 64'(0) - (64'(2) << FRAC_BITS);
	localparam logic [WORD_W-1:0]   Y_MAX_RST = 64'(3) << (FRAC_BITS - 1);
	localparam logic [WORD_W-2:0]   STEP_RST  = 63'(64'(1) << (FRAC_BITS - 8));
	localparam logic [WORD_W-2:0]   THR_RST   = 63'(64'(4) << FRAC_BITS);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MAPX = 4'd1;
	localparam logic [3:0] ST_MAPY = 4'd2;
	localparam logic [3:0] ST_LOOP = 4'd3;
	localparam logic [3:0] ST_SQX  = 4'd4;
	localparam logic [3:0] ST_SQY  = 4'd5;
	localparam logic [3:0] ST_TEST = 4'd6;
	localparam logic [3:0] ST_MXY  = 4'd7;
	localparam logic [3:0] ST_UPD  = 4'd8;
	localparam logic [3:0] ST_FIN  = 4'd9;

	function automatic logic [WORD_W-1:0] sat_add(input logic [WORD_W-1:0] x,
		input logic [WORD_W-1:0] y);
		logic [WORD_W-1:0] s;
		s = x + y;
		if (x[WORD_W-1] == y[WORD_W-1] && s[WORD_W-1] != x[WORD_W-1]) begin
			sat_add = x[WORD_W-1] ? SMIN : SMAX;
		end else begin
			sat_add = s;
		end
	endfunction

	function automatic logic [WORD_W-1:0] abs_val(input logic [WORD_W-1:0] x);
		abs_val = x[WORD_W-1] ? (~x + 1'b1) : x;
	endfunction

	// base +/- pixel*step, exact then clamped, on offset-binary values
	function automatic logic [WORD_W-1:0] offset(input logic [WORD_W-1:0] base,
		input logic [2*WORD_W-1:0] pr, input logic sub);
		logic [WORD_W-1:0] p, ub;
		logic [WORD_W:0]   s;
		p  = (|pr[2*WORD_W-1:WORD_W]) ? {WORD_W{1'b1}} : pr[WORD_W-1:0];
		ub = base ^ SMIN;
		if (sub) begin
			ub = (ub >= p) ? (ub - p) : '0;
		end else begin
			s  = {1'b0, ub} + {1'b0, p};
			ub = s[WORD_W] ? {WORD_W{1'b1}} : s[WORD_W-1:0];
		end
		offset = ub ^ SMIN;
	endfunction

	logic [WORD_W-1:0] x_min_q, y_max_q;
	logic [WORD_W-2:0] x_step_q, y_step_q, thr_q;
	logic [CNT_W-1:0]  max_iter_q;

	logic [3:0]        state_q;
	logic [PIX_W-1:0]  px_q, py_q;
	logic [WORD_W-1:0] cx_q, cy_q, zx_q, zy_q, zx2_q, zy2_q, diff_q, p2_q;
	logic [CNT_W-1:0]  n_q, peak_q;
	logic              esc_q;

	logic              res_valid_q;
	logic [PIX_W-1:0]  out_x_q, out_y_q;
	logic [CNT_W-1:0]  out_iter_q, out_peak_q;
	logic              out_esc_q;

	mbe_mul_req_t        mul_req;
	mbe_mul_rsp_t        mul_rsp;
	logic [WORD_W-1:0]   mul_a, mul_b, mul_fixed;
	logic [2*WORD_W-1:0] mul_prod;

	logic [PIX_W-1:0]  px_in, py_in;
	logic [WORD_W-1:0] mag_sum;
	logic              esc_now, out_free;
	logic [CNT_W-1:0]  n_next;

	assign px_in    = pix.pixel_x & PIX_MASK;
	assign py_in    = pix.pixel_y & PIX_MASK;
	assign mag_sum  = sat_add(zx2_q, zy2_q);
	assign esc_now  = mag_sum > {1'b0, thr_q};
	assign n_next   = n_q + 1'b1;
	assign out_free = !res_valid_q || res.ready;

	assign cfg.ready = 1'b1;
	assign pix.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q    <= X_MIN_RST;
			y_max_q    <= Y_MAX_RST;
			x_step_q   <= STEP_RST;
			y_step_q   <= STEP_RST;
			max_iter_q <= ITER_RST;
			thr_q      <= THR_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_X_MIN:  x_min_q    <= cfg.data;
				REG_Y_MAX:  y_max_q    <= cfg.data;
				REG_X_STEP: x_step_q   <= cfg.data[WORD_W-2:0];
				REG_Y_STEP: y_step_q   <= cfg.data[WORD_W-2:0];
				REG_ITER:   max_iter_q <= cfg.data[CNT_W-1:0];
				REG_THR:    thr_q      <= cfg.data[WORD_W-2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		mul_req = '0;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			ST_IDLE: if (pix.valid) begin
				mul_req.start = 1'b1;
				mul_a         = WORD_W'(px_in);
				mul_b         = {1'b0, x_step_q};
			end
			ST_MAPX: if (mul_rsp.done) begin
				mul_req.start = 1'b1;
				mul_a         = WORD_W'(py_q);
				mul_b         = {1'b0, y_step_q};
			end
			ST_LOOP: begin
				mul_req.start = 1'b1;
				mul_a         = abs_val(zx_q);
				mul_b         = abs_val(zx_q);
			end
			ST_SQX: if (mul_rsp.done) begin
				mul_req.start = 1'b1;
				mul_a         = abs_val(zy_q);
				mul_b         = abs_val(zy_q);
			end
			ST_TEST: if (!esc_now) begin
				mul_req.start = 1'b1;
				mul_req.neg   = zx_q[WORD_W-1] ^ zy_q[WORD_W-1];
				mul_a         = abs_val(zx_q);
				mul_b         = abs_val(zy_q);
			end
			default: ;
		endcase
	end

	mbe_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.a      (mul_a),
		.b      (mul_b),
		.rsp    (mul_rsp),
		.prod   (mul_prod),
		.fixed  (mul_fixed)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			n_q         <= '0;
			esc_q       <= 1'b0;
			peak_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (state_q == ST_FIN && out_free) || (res_valid_q && !res.ready);
			unique case (state_q)
				ST_IDLE: if (pix.valid) begin
					state_q <= ST_MAPX;
				end
				ST_MAPX: if (mul_rsp.done) begin
					state_q <= ST_MAPY;
				end
				ST_MAPY: if (mul_rsp.done) begin
					n_q   <= '0;
					esc_q <= 1'b0;
					state_q <= (max_iter_q == '0) ? ST_FIN : ST_LOOP;
				end
				ST_LOOP: state_q <= ST_SQX;
				ST_SQX: if (mul_rsp.done) begin
					state_q <= ST_SQY;
				end
				ST_SQY: if (mul_rsp.done) begin
					state_q <= ST_TEST;
				end
				ST_TEST: begin
					if (esc_now) begin
						esc_q   <= 1'b1;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_MXY;
					end
				end
				ST_MXY: if (mul_rsp.done) begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					n_q     <= n_next;
					state_q <= (n_next == max_iter_q) ? ST_FIN : ST_LOOP;
				end
				ST_FIN: if (out_free) begin
					if (esc_q && n_q > peak_q) begin
						peak_q <= n_q;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (pix.valid) begin
				px_q <= px_in;
				py_q <= py_in;
			end
			ST_MAPX: if (mul_rsp.done) begin
				cx_q <= offset(x_min_q, mul_prod, 1'b0);
			end
			ST_MAPY: if (mul_rsp.done) begin
				cy_q <= offset(y_max_q, mul_prod, 1'b1);
				zx_q <= '0;
				zy_q <= '0;
			end
			ST_SQX: if (mul_rsp.done) begin
				zx2_q <= mul_fixed;
			end
			ST_SQY: if (mul_rsp.done) begin
				zy2_q <= mul_fixed;
			end
			ST_TEST: diff_q <= zx2_q - zy2_q;
			ST_MXY: if (mul_rsp.done) begin
				p2_q <= sat_add(mul_fixed, mul_fixed);
			end
			ST_UPD: begin
				zy_q <= sat_add(p2_q, cy_q);
				zx_q <= sat_add(diff_q, cx_q);
			end
			ST_FIN: if (out_free) begin
				out_x_q    <= px_q;
				out_y_q    <= py_q;
				out_iter_q <= n_q;
				out_esc_q  <= esc_q;
				out_peak_q <= (esc_q && n_q > peak_q) ? n_q : peak_q;
			end
			default: ;
		endcase
	end

	assign res.valid      = res_valid_q;
	assign res.out_x      = out_x_q;
	assign res.out_y      = out_y_q;
	assign res.iterations = out_iter_q;
	assign res.escaped    = out_esc_q;
	assign res.peak_count = out_peak_q;

	`MBE_ASSERT_IMPL(a_idle_mul_free, state_q == ST_IDLE, !mul_rsp.busy)
	`MBE_ASSERT_NEXT(a_start_busy, mul_req.start, mul_rsp.busy)
	`MBE_ASSERT_IMPL(a_cnt_range, state_q >= ST_SQX && state_q <= ST_UPD, n_q < max_iter_q)
	`MBE_ASSERT_IMPL(a_peak_bound, res.valid && res.escaped, res.peak_count >= res.iterations)

endmodule

// ===== tb/sv/tb_mandelbrot_escape_time_unit.sv =====
`timescale 1ns / 100ps

import mbe_pkg::*;

typedef struct packed {
	logic [PIX_W-1:0] x;
	logic [PIX_W-1:0] y;
	logic [CNT_W-1:0] iterations;
	logic             escaped;
	logic [CNT_W-1:0] peak_count;
} escape_res_t;

class escape_board;
	logic [WORD_W-1:0] x_min, y_max;
	logic [WORD_W-2:0] x_step, y_step, threshold;
	logic [CNT_W-1:0]  iter_limit, peak;
	escape_res_t       expected_q[$];
	int                errors;

	function new();
		x_min      = 64'd0 - (64'd2 << FRAC_DEF);
		y_max      = 64'd3 << (FRAC_DEF - 1);
		x_step     = 63'd1 << (FRAC_DEF - 8);
		y_step     = 63'd1 << (FRAC_DEF - 8);
		iter_limit = ITER_RST;
		threshold  = 63'd4 << FRAC_DEF;
		peak       = '0;
		errors     = 0;
	endfunction

	function int pending();
		return expected_q.size();
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
		case (idx)
			REG_X_MIN:  x_min = val;
			REG_Y_MAX:  y_max = val;
			REG_X_STEP: x_step = val[WORD_W-2:0];
			REG_Y_STEP: y_step = val[WORD_W-2:0];
			REG_ITER:   iter_limit = val[CNT_W-1:0];
			REG_THR:    threshold = val[WORD_W-2:0];
			default:    ;
		endcase
	endfunction

	function logic [WORD_W-1:0] sat_sum(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
		logic [WORD_W-1:0] s;
		s = a + b;
		if (a[WORD_W-1] == b[WORD_W-1] && s[WORD_W-1] != a[WORD_W-1])
			return a[WORD_W-1] ? SMIN : SMAX;
		return s;
	endfunction

	// magnitude product, truncated, sign applied, saturated
	function logic [WORD_W-1:0] fix_mul(logic [WORD_W-1:0] a, logic [WORD_W-1:0] b);
		logic [WORD_W-1:0]   ma, mb, q;
		logic [2*WORD_W-1:0] full;
		logic                neg;
		ma   = a[WORD_W-1] ? 64'd0 - a : a;
		mb   = b[WORD_W-1] ? 64'd0 - b : b;
		neg  = a[WORD_W-1] ^ b[WORD_W-1];
		full = {64'd0, ma} * {64'd0, mb};
		if ((full >> (WORD_W + FRAC_DEF)) != 0)
			return neg ? SMIN : SMAX;
		q = full[FRAC_DEF +: WORD_W];
		if (neg)
			return q[WORD_W-1] ? SMIN : 64'd0 - q;
		return q[WORD_W-1] ? SMAX : q;
	endfunction

	// base +/- pix*step, exact in offset binary, clamped
	function logic [WORD_W-1:0] map_coord(logic [WORD_W-1:0] base, logic [PIX_W-1:0] pix,
		logic [WORD_W-2:0] step, bit sub);
		logic [WORD_W-1:0] ub, p;
		logic [75:0]       prod;
		ub   = base ^ SMIN;
		prod = 76'(pix) * 76'(step);
		p    = (prod[75:WORD_W] != 0) ? '1 : prod[WORD_W-1:0];
		if (sub)
			ub = (ub >= p) ? ub - p : '0;
		else
			ub = (ub > ~p) ? '1 : ub + p;
		return ub ^ SMIN;
	endfunction

	function void note_pixel(logic [PIX_W-1:0] px_in, logic [PIX_W-1:0] py_in);
		logic [PIX_W-1:0]  px, py;
		logic [WORD_W-1:0] cx, cy, zx, zy, zx2, zy2, mag, prd;
		logic [CNT_W-1:0]  n;
		bit                stop;
		escape_res_t       r;
		px   = px_in & PIX_W'(DIM_DEF - 1);
		py   = py_in & PIX_W'(DIM_DEF - 1);
		cx   = map_coord(x_min, px, x_step, 1'b0);
		cy   = map_coord(y_max, py, y_step, 1'b1);
		zx   = '0;
		zy   = '0;
		n    = '0;
		stop = 1'b0;
		while (!stop && n < iter_limit) begin
			zx2 = fix_mul(zx, zx);
			zy2 = fix_mul(zy, zy);
			mag = sat_sum(zx2, zy2);
			if (mag > {1'b0, threshold}) begin
				stop = 1'b1;
			end else begin
				prd = fix_mul(zx, zy);
				zy  = sat_sum(sat_sum(prd, prd), cy);
				zx  = sat_sum(zx2 - zy2, cx);
				n   = n + 1'b1;
			end
		end
		r.x          = px;
		r.y          = py;
		r.iterations = n;
		r.escaped    = (n < iter_limit);
		if (r.escaped && n > peak)
			peak = n;
		r.peak_count = peak;
		expected_q.push_back(r);
	endfunction

	function void flag_field(escape_res_t want, string what, logic [CNT_W-1:0] exp_v,
		logic [CNT_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: pixel (%0d,%0d) %s expected %0d, got %0d",
				$time, want.x, want.y, what, exp_v, got_v);
			errors++;
		end
	endfunction

	function void check_result(escape_res_t got);
		escape_res_t want;
		if (expected_q.size() == 0) begin
			$display("%0t: result beat with nothing pending: x=%0d y=%0d iterations=%0d",
				$time, got.x, got.y, got.iterations);
			errors++;
			return;
		end
		want = expected_q.pop_front();
		flag_field(want, "out_x", CNT_W'(want.x), CNT_W'(got.x));
		flag_field(want, "out_y", CNT_W'(want.y), CNT_W'(got.y));
		flag_field(want, "iterations", want.iterations, got.iterations);
		flag_field(want, "escaped", CNT_W'(want.escaped), CNT_W'(got.escaped));
		flag_field(want, "peak_count", want.peak_count, got.peak_count);
	endfunction
endclass

module tb_mandelbrot_escape_time_unit;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic [WORD_W-1:0]    ONE_Q        = 64'd1 << FRAC_DEF;
	localparam logic [WORD_W-1:0]    STEP_DEF     = 64'd1 << (FRAC_DEF - 8);
	localparam int HOLD_CYCLES    = 3000;
	localparam int WATCHDOG_LIMIT = 100000;
	localparam int SETTLE_CYCLES  = 2000;

	logic clk = 1'b0;
	logic arst_n;
	bit   hold_request = 1'b0;
	int   idle_cycles = 0;

	escape_board board;

	mbe_cfg_if cfg_bus ();
	mbe_pix_if pix_bus ();
	mbe_res_if res_bus ();

	mandelbrot_escape_time_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.pix    (pix_bus),
		.res    (res_bus)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (cfg_bus.valid && cfg_bus.ready)
				board.set_reg(cfg_bus.index, cfg_bus.data);
			if (pix_bus.valid && pix_bus.ready)
				board.note_pixel(pix_bus.pixel_x, pix_bus.pixel_y);
			if (res_bus.valid && res_bus.ready)
				board.check_result({res_bus.out_x, res_bus.out_y, res_bus.iterations,
					res_bus.escaped, res_bus.peak_count});
		end
	end

	always @(posedge clk) begin
		if ((cfg_bus.valid && cfg_bus.ready) || (pix_bus.valid && pix_bus.ready) ||
			(res_bus.valid && res_bus.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("mandelbrot_escape_time_unit regression: fail");
			$finish;
		end
	end

	// result side: random stall modes, plus one long hold-off on request
	initial begin : sink_side
		int mode, mode_left, tick;
		res_bus.ready <= 1'b0;
		mode      = 0;
		mode_left = 0;
		tick      = 0;
		forever begin
			@(posedge clk);
			tick++;
			if (hold_request) begin
				hold_request = 1'b0;
				res_bus.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 256);
			end
			mode_left--;
			case (mode)
				0:       res_bus.ready <= 1'b1;
				1:       res_bus.ready <= 1'($urandom_range(0, 1));
				2:       res_bus.ready <= ($urandom_range(0, 4) == 0);
				default: res_bus.ready <= ((tick % 5) < 2);
			endcase
		end
	end

	function automatic logic [WORD_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [PIX_W-1:0] pick_coord();
		case ($urandom_range(0, 15))
			0:       return '0;
			1:       return '1;
			default: return PIX_W'($urandom_range(0, 4095));
		endcase
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] val);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= val;
		do @(posedge clk); while (!cfg_bus.ready);
	endtask

	task automatic program_view(logic [WORD_W-1:0] xm, logic [WORD_W-1:0] ym,
		logic [WORD_W-1:0] xs, logic [WORD_W-1:0] ys, logic [WORD_W-1:0] lim,
		logic [WORD_W-1:0] thr);
		write_reg(REG_X_MIN, xm);
		write_reg(REG_Y_MAX, ym);
		write_reg(REG_X_STEP, xs);
		write_reg(REG_Y_STEP, ys);
		write_reg(REG_ITER, lim);
		write_reg(REG_THR, thr);
		cfg_bus.valid <= 1'b0;
	endtask

	task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
		pix_bus.valid   <= 1'b1;
		pix_bus.pixel_x <= px;
		pix_bus.pixel_y <= py;
		do @(posedge clk); while (!pix_bus.ready);
	endtask

	task automatic stream_pixels(int total);
		int burst;
		burst = $urandom_range(1, 24);
		for (int i = 0; i < total; i++) begin
			send_pixel(pick_coord(), pick_coord());
			burst = burst - 1;
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				if ($urandom_range(0, 3) != 0) begin
					pix_bus.valid <= 1'b0;
					repeat ($urandom_range(1, 40)) @(posedge clk);
				end
			end
		end
		pix_bus.valid <= 1'b0;
	endtask

	task automatic settle();
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stimulus
		logic [WORD_W-1:0] xm, ym, xs, ys, lim, thr;
		board = new();
		arst_n          <= 1'b0;
		cfg_bus.valid   <= 1'b0;
		cfg_bus.index   <= '0;
		cfg_bus.data    <= '0;
		pix_bus.valid   <= 1'b0;
		pix_bus.pixel_x <= '0;
		pix_bus.pixel_y <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// reset view: corners, c = 1.5i, and c = 0 and c = -1, which stay inside
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd512, 12'd384);
		send_pixel(12'd256, 12'd384);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd512, 12'd0);
		pix_bus.valid <= 1'b0;
		settle();

		// zero threshold, junk above register widths, unmapped indexes
		write_reg(REG_SPARE_LO, rand_word());
		write_reg(REG_SPARE_HI, rand_word());
		program_view(64'd0, 64'd0, SMIN | STEP_DEF, SMIN | STEP_DEF,
			64'hABCD_0000_0000_0008, SMIN);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd0);
		send_pixel(12'd0, 12'd1);
		send_pixel(12'd4095, 12'd4095);
		pix_bus.valid <= 1'b0;
		settle();

		// zero limit
		program_view(0 - (ONE_Q << 1), 64'd3 << (FRAC_DEF - 1), STEP_DEF, STEP_DEF,
			64'd0, ONE_Q << 2);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd7, 12'd9);
		pix_bus.valid <= 1'b0;
		settle();

		// largest limit with saturating coordinates, so every pixel escapes after its first iteration
		program_view(SMAX, SMIN, SMAX, '1, 64'h0000_0000_0000_FFFF, ONE_Q << 2);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd1, 12'd2048);
		send_pixel(12'd2048, 12'd1);
		pix_bus.valid <= 1'b0;
		settle();
		program_view(SMIN, SMAX, 64'd0, 64'd0, 64'h0000_0000_0000_FFFF, ONE_Q << 2);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd123, 12'd4000);
		pix_bus.valid <= 1'b0;
		settle();

		// threshold at the top of its range: nothing escapes
		program_view(0 - (ONE_Q << 1), 64'd3 << (FRAC_DEF - 1), STEP_DEF, STEP_DEF,
			64'd5, '1);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		pix_bus.valid <= 1'b0;
		settle();

		for (int ph = 0; ph < 12; ph++) begin
			if (ph % 4 == 3) begin
				xm  = rand_word();
				ym  = rand_word();
				xs  = rand_word();
				ys  = rand_word();
				lim = rand_word();
				lim[CNT_W-1:0] = CNT_W'($urandom_range(1, 12));
				thr = rand_word();
			end else begin
				xm  = 64'd0 - ONE_Q - (rand_word() >> 8);
				ym  = ONE_Q + (rand_word() >> 9);
				xs  = (ONE_Q >> 12) + (rand_word() >> 19);
				ys  = (ONE_Q >> 12) + (rand_word() >> 19);
				lim = (ph == 6) ? 64'd256 : (ph == 9) ? 64'd1 : 64'($urandom_range(2, 32));
				thr = ($urandom_range(0, 2) == 0) ? (rand_word() >> 5) : (ONE_Q << 2);
			end
			program_view(xm, ym, xs, ys, lim, thr);
			if (ph == 1)
				hold_request = 1'b1;
			stream_pixels((ph == 6) ? 40 : 150);
			settle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.pending() != 0) begin
			$display("%0t: %0d results never arrived", $time, board.pending());
			board.errors++;
		end
		if (board.errors == 0)
			$display("mandelbrot_escape_time_unit regression: pass");
		else
			$display("mandelbrot_escape_time_unit regression: fail");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/mbe_pkg.sv
rtl/core/mbe_cfg_if.sv
rtl/core/mbe_pix_if.sv
rtl/core/mbe_res_if.sv
rtl/core/mbe_mul.sv
rtl/core/mandelbrot_escape_time_unit.sv
tb/sv/tb_mandelbrot_escape_time_unit.sv
